/* rtl/lst_pkg.sv */
// Shared constants and types for the LRU slot tracker.
// No dependencies; imported by lst_cell and lru_slot_tracker.
package lst_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int KEY_BITS  = 32;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int CAP_W     = 5;

  localparam logic OP_TOUCH = 1'b0;
  localparam logic OP_LIST  = 1'b1;

  // Word index of the capacity register on the configuration port.
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_SLOTS);

  // Broadcast control from the sequencer to every cell of the recency chain.
  typedef struct packed {
    logic                touch_en;
    logic                rotate_en;
    logic [CNT_W-1:0]    occ;
    logic [CNT_W-1:0]    miss_pos;
    logic [CNT_W-1:0]    tail_pos;
    logic [SLOT_W-1:0]   hint;
    logic [KEY_BITS-1:0] key;
    logic [SLOT_W-1:0]   head_slot;
    logic [KEY_BITS-1:0] head_key;
  } cell_ctl_t;

endpackage

/* rtl/lst_cell.sv */
// One position of the recency chain: holds a slot number and its key.
// Depends on lst_pkg for widths and the cell_ctl_t control struct.
module lst_cell import lst_pkg::*; (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic                hit_any,
  input  logic [SLOT_W-1:0]   new_slot,
  input  logic [SLOT_W-1:0]   cell_idx,
  input  logic [SLOT_W-1:0]   prev_slot,
  input  logic [KEY_BITS-1:0] prev_key,
  input  logic [SLOT_W-1:0]   next_slot,
  input  logic [KEY_BITS-1:0] next_key,
  input  logic                shift_in,
  output logic                shift_out,
  output logic                match,
  output logic [SLOT_W-1:0]   slot,
  output logic [SLOT_W-1:0]   tail_slot,
  output logic [KEY_BITS-1:0] key_o
);

  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]    pos;
  logic                valid;
  logic                sel;
  logic                at_tail;

  always_comb begin
    pos       = CNT_W'(cell_idx);
    valid     = pos < ctl.occ;
    match     = valid && (slot_r == ctl.hint) && (key_r == ctl.key);
    // The target position is the hit entry, else the tail or the first free place.
    sel       = hit_any ? match : (pos == ctl.miss_pos);
    shift_out = sel | shift_in;
    at_tail   = pos == ctl.tail_pos;
    tail_slot = at_tail ? slot_r : '0;

    slot_nxt = slot_r;
    key_nxt  = key_r;
    if (ctl.touch_en) begin
      if (cell_idx == '0) begin
        slot_nxt = new_slot;
        key_nxt  = ctl.key;
      end else if (shift_out) begin
        slot_nxt = prev_slot;
        key_nxt  = prev_key;
      end
    end else if (ctl.rotate_en && valid) begin
      // Listing rotates the occupied part of the chain by one place per entry.
      if (at_tail) begin
        slot_nxt = ctl.head_slot;
        key_nxt  = ctl.head_key;
      end else begin
        slot_nxt = next_slot;
        key_nxt  = next_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    key_r  <= key_nxt;
  end

  assign slot  = slot_r;
  assign key_o = key_r;

endmodule

/* rtl/lru_slot_tracker.sv */
// LRU slot tracker top level: stream ports, capacity register and sequencer.
// Depends on lst_pkg and instantiates one lst_cell per slot.
// Results pass the input holding register, then the output register, and wait while the
// result stream stalls. A new touch is taken every cycle while the stream is not stalled; a
// list holds the chain until all occupied entries (or one empty entry) are emitted, one entry
// per cycle when not stalled, as the whole chain rotates one place to bring each to its head.
// Reset (rst_n, synchronous, active low) empties the table and sets capacity to 16;
// no clearing pass is needed, so the block accepts transfers right after reset.
module lru_slot_tracker import lst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream. in_tdata: [3:0] slot_hint, [35:4] key, [39:36] zero.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // in_tuser: [0] opcode.
  input  logic [0:0]  in_tuser,
  // Result stream. out_tdata: [3:0] slot, [4] hit, [5] evicted, [37:6] entry_key,
  // [42:38] occupied, [47:43] zero.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  // out_tuser: [0] entry_valid.
  output logic [0:0]  out_tuser,
  output logic        out_tlast,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Capacity register and occupancy.
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] eff_cap;

  // Input holding register: one item waits here while the result side is busy.
  logic                item_valid_r, item_valid_nxt;
  logic                item_op_r;
  logic [SLOT_W-1:0]   item_hint_r;
  logic [KEY_BITS-1:0] item_key_r;

  // Count of list entries already emitted for the current list operation.
  logic [CNT_W-1:0] list_cnt_r, list_cnt_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic                out_evicted_r, out_evicted_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic                out_evalid_r, out_evalid_nxt;
  logic [CNT_W-1:0]    out_occ_r, out_occ_nxt;
  logic                out_last_r, out_last_nxt;

  // Chain wiring.
  cell_ctl_t           ctl;
  logic                hit_any;
  logic                full;
  logic [SLOT_W-1:0]   new_slot;
  logic [SLOT_W-1:0]   evict_slot;
  logic [SLOT_W-1:0]   slot_a [MAX_SLOTS];
  logic [KEY_BITS-1:0] key_a [MAX_SLOTS];
  logic [SLOT_W-1:0]   tail_a [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] match_a;
  logic [MAX_SLOTS:0]  shift_a;

  logic cfg_wr;
  logic in_xfer;
  logic out_free;
  logic go;
  logic go_touch;
  logic go_list;
  logic list_last;
  logic item_done;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? 32'(cap_r) : 32'd0;

  // A written 0 behaves as 1 and anything above the slot count as the slot count.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CNT_W'(cap_r) > CNT_W'(MAX_SLOTS)) begin
      eff_cap = CNT_W'(MAX_SLOTS);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  // The result register is free when it is empty or its transfer completes now.
  assign out_free  = !out_valid_r || out_tready;
  assign go        = item_valid_r && out_free;
  assign go_touch  = go && (item_op_r == OP_TOUCH);
  assign go_list   = go && (item_op_r == OP_LIST);
  assign list_last = (list_cnt_r + CNT_W'(1)) == occ_r;
  assign item_done = go_touch || (go_list && ((occ_r == '0) || list_last));

  // A new item is taken whenever the holding register is empty or empties now.
  assign in_tready = !item_valid_r || item_done;
  assign in_xfer   = in_tvalid && in_tready;

  // A table that is full evicts its least recent entry, which sits at the tail.
  assign full = occ_r >= eff_cap;

  always_comb begin
    ctl.touch_en  = go_touch;
    ctl.rotate_en = go_list && (occ_r != '0);
    ctl.occ       = occ_r;
    ctl.tail_pos  = occ_r - CNT_W'(1);
    ctl.miss_pos  = full ? (occ_r - CNT_W'(1)) : occ_r;
    ctl.hint      = item_hint_r;
    ctl.key       = item_key_r;
    ctl.head_slot = slot_a[0];
    ctl.head_key  = key_a[0];
  end

  always_comb begin
    evict_slot = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      evict_slot = evict_slot | tail_a[i];
    end
  end

  assign hit_any = |match_a;

  // On a hit the key keeps its slot; a miss reuses the tail slot or takes the next free one.
  always_comb begin
    if (hit_any) begin
      new_slot = item_hint_r;
    end else if (full) begin
      new_slot = evict_slot;
    end else begin
      new_slot = occ_r[SLOT_W-1:0];
    end
  end

  // The chain: position 0 is the most recent entry. A touch shifts the entries in front
  // of the target position down by one; a list rotates the occupied entries.
  assign shift_a[MAX_SLOTS] = 1'b0;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    logic [SLOT_W-1:0]   prv_slot;
    logic [KEY_BITS-1:0] prv_key;
    logic [SLOT_W-1:0]   nxt_slot;
    logic [KEY_BITS-1:0] nxt_key;

    if (g == 0) begin : g_first
      assign prv_slot = '0;
      assign prv_key  = '0;
    end else begin : g_inner
      assign prv_slot = slot_a[g-1];
      assign prv_key  = key_a[g-1];
    end

    if (g == MAX_SLOTS - 1) begin : g_last
      assign nxt_slot = slot_a[g];
      assign nxt_key  = key_a[g];
    end else begin : g_body
      assign nxt_slot = slot_a[g+1];
      assign nxt_key  = key_a[g+1];
    end

    lst_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .hit_any   (hit_any),
      .new_slot  (new_slot),
      .cell_idx  (SLOT_W'(g)),
      .prev_slot (prv_slot),
      .prev_key  (prv_key),
      .next_slot (nxt_slot),
      .next_key  (nxt_key),
      .shift_in  (shift_a[g+1]),
      .shift_out (shift_a[g]),
      .match     (match_a[g]),
      .slot      (slot_a[g]),
      .tail_slot (tail_a[g]),
      .key_o     (key_a[g])
    );
  end

  // Sequencer and result formation.
  always_comb begin
    cap_nxt        = cap_r;
    occ_nxt        = occ_r;
    item_valid_nxt = item_valid_r;
    list_cnt_nxt   = list_cnt_r;

    out_valid_nxt   = out_valid_r && !out_tready;
    out_slot_nxt    = out_slot_r;
    out_hit_nxt     = out_hit_r;
    out_evicted_nxt = out_evicted_r;
    out_key_nxt     = out_key_r;
    out_evalid_nxt  = out_evalid_r;
    out_occ_nxt     = out_occ_r;
    out_last_nxt    = out_last_r;

    if (in_xfer) begin
      item_valid_nxt = 1'b1;
    end else if (item_done) begin
      item_valid_nxt = 1'b0;
    end

    if (go_touch) begin
      if (!hit_any && !full) begin
        occ_nxt = occ_r + CNT_W'(1);
      end
      out_valid_nxt   = 1'b1;
      out_slot_nxt    = new_slot;
      out_hit_nxt     = hit_any;
      out_evicted_nxt = !hit_any && full;
      out_key_nxt     = '0;
      out_evalid_nxt  = 1'b0;
      out_occ_nxt     = (!hit_any && !full) ? (occ_r + CNT_W'(1)) : occ_r;
      out_last_nxt    = 1'b1;
    end else if (go_list) begin
      out_valid_nxt   = 1'b1;
      out_slot_nxt    = '0;
      out_hit_nxt     = 1'b0;
      out_evicted_nxt = 1'b0;
      out_occ_nxt     = occ_r;
      if (occ_r == '0) begin
        // An empty table still answers a list with one empty entry.
        out_key_nxt    = '0;
        out_evalid_nxt = 1'b0;
        out_last_nxt   = 1'b1;
      end else begin
        out_key_nxt    = key_a[0];
        out_evalid_nxt = 1'b1;
        out_last_nxt   = list_last;
        list_cnt_nxt   = list_last ? '0 : (list_cnt_r + CNT_W'(1));
      end
    end

    // A capacity write empties the table; the user must write only while idle (not enforced).
    if (cfg_wr && (cfg_paddr[2] == REG_CAPACITY)) begin
      cap_nxt      = cfg_pwdata[CAP_W-1:0];
      occ_nxt      = '0;
      list_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RESET;
      occ_r        <= '0;
      item_valid_r <= 1'b0;
      list_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cap_r        <= cap_nxt;
      occ_r        <= occ_nxt;
      item_valid_r <= item_valid_nxt;
      list_cnt_r   <= list_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_op_r   <= in_tuser[0];
      item_hint_r <= in_tdata[SLOT_W-1:0];
      item_key_r  <= in_tdata[SLOT_W +: KEY_BITS];
    end
    out_slot_r    <= out_slot_nxt;
    out_hit_r     <= out_hit_nxt;
    out_evicted_r <= out_evicted_nxt;
    out_key_r     <= out_key_nxt;
    out_evalid_r  <= out_evalid_nxt;
    out_occ_r     <= out_occ_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {5'd0, out_occ_r, out_key_r, out_evicted_r, out_hit_r, out_slot_r};
  assign out_tuser[0] = out_evalid_r;
  assign out_tlast    = out_last_r;

`ifndef NO_ASSERTIONS
  // The table never holds more entries than the capacity allows.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= eff_cap)
    else $error("occupancy exceeds capacity");

  // Occupied positions carry distinct slots, so at most one can match the hint.
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_a))
    else $error("more than one chain position matched");

  // Every touch finds a target position somewhere in the chain.
  a_touch_target: assert property (@(posedge clk) disable iff (!rst_n)
    go_touch |-> shift_a[0])
    else $error("touch found no target position");

  // A hit leaves the occupancy unchanged.
  a_hit_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (go_touch && hit_any) |=> $stable(occ_r))
    else $error("hit changed occupancy");

  // The list counter stays inside the occupied part of the chain.
  a_list_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (list_cnt_r == '0) || (list_cnt_r < occ_r))
    else $error("list counter out of range");
`endif

endmodule
